FILE: src/wsr_pkg.sv
// ----------------------------------------------------------------------------
// wsr_pkg
// Shared types, constants and helper functions of the 2D workgroup shape ranker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wsr_pkg;

  localparam int AXIS_W    = 11;
  localparam int WORK_W    = 24;
  localparam int LIM_W     = 5;
  localparam int CFG_IDX_W = 3;
  localparam int RU_W      = 25;
  localparam int AGAP_W    = 35;
  localparam int AREA_W    = 48;
  localparam int WASTE_W   = 50;
  localparam int TOT_W     = 22;

  localparam int SLOT_W    = 4;
  localparam int POW_SLOTS = 11;
  localparam logic [SLOT_W-1:0] SLOT_LIMIT = 4'd11;
  localparam logic [SLOT_W-1:0] SLOT_WORK  = 4'd12;

  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_STEPS   = 24;

  localparam int DEFAULT_RANK_DEPTH = 16;
  localparam int DEFAULT_AXIS_CAP   = 1024;

  localparam logic [AXIS_W-1:0] THREAD_FLOOR  = 11'd8;
  localparam logic [AXIS_W-1:0] RST_SUBGROUP  = 11'd32;
  localparam logic [AXIS_W-1:0] RST_SIMD      = 11'd32;
  localparam logic [AXIS_W-1:0] RST_MAX_TOTAL = 11'd256;
  localparam logic [AXIS_W-1:0] RST_MAX_X     = 11'd256;
  localparam logic [AXIS_W-1:0] RST_MAX_Y     = 11'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SUBGROUP,
    REG_SIMD,
    REG_MAX_TOTAL,
    REG_MAX_X,
    REG_MAX_Y
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_SPLIT,
    OP_RX_LIMIT,
    OP_RX_WORK,
    OP_RY_LIMIT,
    OP_RY_WORK
  } div_op_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_TGT,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_DRAIN,
    B_EMIT
  } back_state_t;

  typedef struct packed {
    logic [AXIS_W-1:0] sg_width;
    logic [AXIS_W-1:0] simd_width;
    logic [AXIS_W-1:0] total_cap;
    logic [AXIS_W-1:0] max_threads_x;
    logic [AXIS_W-1:0] max_threads_y;
  } cfg_t;

  typedef struct packed {
    logic [WORK_W-1:0] eh;
    logic [WORK_W-1:0] ew;
    logic [AREA_W-1:0] area;
    logic [AXIS_W-1:0] budget;
    logic [AXIS_W-1:0] target;
    logic [AXIS_W-1:0] minthr;
    logic [AXIS_W-1:0] ax;
    logic [AXIS_W-1:0] ay;
    logic [AXIS_W-1:0] wlx;
    logic [AXIS_W-1:0] wly;
    logic [RU_W-1:0]   rxl;
    logic [RU_W-1:0]   rxw;
    logic [RU_W-1:0]   ryl;
    logic [RU_W-1:0]   ryw;
    logic [LIM_W-1:0]  lim;
  } job_t;

  // Lower key ranks first: aspect gap, target gap, waste, then inverted size fields.
  typedef struct packed {
    logic [AGAP_W-1:0]  agap;
    logic [AXIS_W-1:0]  tgap;
    logic [WASTE_W-1:0] waste;
    logic [AXIS_W-1:0]  ntot;
    logic [AXIS_W-1:0]  nx;
    logic [AXIS_W-1:0]  ny;
  } cand_t;

  function automatic logic [AXIS_W-1:0] slot_val(
    input logic [SLOT_W-1:0] idx,
    input logic [AXIS_W-1:0] lim,
    input logic [AXIS_W-1:0] wl
  );
    logic [AXIS_W-1:0] v;
    if (idx < SLOT_W'(POW_SLOTS)) begin
      v = AXIS_W'(1) << idx;
    end else if (idx == SLOT_LIMIT) begin
      v = lim;
    end else begin
      v = wl;
    end
    return v;
  endfunction

  function automatic logic slot_ok(
    input logic [SLOT_W-1:0] idx,
    input logic [AXIS_W-1:0] lim,
    input logic [AXIS_W-1:0] wl
  );
    logic ok;
    logic wl_pow2;
    wl_pow2 = ((wl & (wl - AXIS_W'(1))) == '0);
    if (idx < SLOT_W'(POW_SLOTS)) begin
      ok = ((AXIS_W'(1) << idx) < lim);
    end else if (idx == SLOT_LIMIT) begin
      ok = 1'b1;
    end else if (idx == SLOT_WORK) begin
      ok = (wl != lim) && !(wl_pow2 && (wl < lim));
    end else begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic [RU_W-1:0] slot_ru(
    input logic [SLOT_W-1:0] idx,
    input logic [WORK_W-1:0] e,
    input logic [AXIS_W-1:0] v,
    input logic [RU_W-1:0]   rl,
    input logic [RU_W-1:0]   rw
  );
    logic [RU_W-1:0] m;
    logic [RU_W-1:0] r;
    m = RU_W'(v) - RU_W'(1);
    if (idx < SLOT_W'(POW_SLOTS)) begin
      r = (RU_W'(e) + m) & ~m;
    end else if (idx == SLOT_LIMIT) begin
      r = rl;
    end else begin
      r = rw;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/wsr_if.sv
// ----------------------------------------------------------------------------
// wsr channel interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface wsr_req_if;
  logic        valid;
  logic        ready;
  logic [23:0] work_height;
  logic [23:0] work_width;
  logic [10:0] wide_waves;
  logic [10:0] thread_cap;
  logic [4:0]  result_limit;
  modport source (output valid, work_height, work_width, wide_waves, thread_cap,
                  result_limit, input ready);
  modport sink (input valid, work_height, work_width, wide_waves, thread_cap,
                result_limit, output ready);
endinterface

interface wsr_rsp_if;
  logic        valid;
  logic        ready;
  logic [10:0] shape_x;
  logic [10:0] shape_y;
  logic        is_last;
  logic        none_found;
  modport source (output valid, shape_x, shape_y, is_last, none_found, input ready);
  modport sink (input valid, shape_x, shape_y, is_last, none_found, output ready);
endinterface

interface wsr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [10:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/workgroup_shape_ranker_2d_top.sv
// ----------------------------------------------------------------------------
// workgroup_shape_ranker_2d_top
// Ranks 2D workgroup shapes for a work size under device thread limits.
//
// Channels: req takes one request (work size, wide waves, thread cap, result
// limit); rsp returns the ranked shapes of that request in order, is_last on
// the final one, or a single none_found item. cfg writes device limits by
// index; ready is always high and writes are expected while the block idles.
// Flow: setup runs five serial divisions on the shared divider, then target
// and push; the scoring back then scans the candidate pairs, drains its
// pipeline and streams the results from its output register, one result per
// cycle while rsp.ready holds. The request rate is set by the pair scan of
// the scoring back and the result stream; setup of the next request overlaps
// through a two-entry job queue.
// Reset: limits return to defaults, queue and pipelines empty, no items out.
// Stall: a held rsp item stays in the output register; scoring waits, the
// queue fills, and req.ready stays low once setup cannot push its job.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module workgroup_shape_ranker_2d_top #(
  parameter int RANK_DEPTH = wsr_pkg::DEFAULT_RANK_DEPTH,
  parameter int AXIS_CAP   = wsr_pkg::DEFAULT_AXIS_CAP
) (
  input  logic      clk,
  input  logic      rst,
  wsr_cfg_if.sink   cfg,
  wsr_req_if.sink   req,
  wsr_rsp_if.source rsp
);

  wsr_pkg::cfg_t regs;
  wsr_pkg::job_t push_job, head;
  logic          push, full, pop, empty;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.sg_width      <= wsr_pkg::RST_SUBGROUP;
      regs.simd_width    <= wsr_pkg::RST_SIMD;
      regs.total_cap     <= wsr_pkg::RST_MAX_TOTAL;
      regs.max_threads_x <= wsr_pkg::RST_MAX_X;
      regs.max_threads_y <= wsr_pkg::RST_MAX_Y;
    end else if (cfg.valid) begin
      unique case (wsr_pkg::reg_idx_t'(cfg.index))
        wsr_pkg::REG_SUBGROUP:  regs.sg_width      <= cfg.data;
        wsr_pkg::REG_SIMD:      regs.simd_width    <= cfg.data;
        wsr_pkg::REG_MAX_TOTAL: regs.total_cap     <= cfg.data;
        wsr_pkg::REG_MAX_X:     regs.max_threads_x <= cfg.data;
        wsr_pkg::REG_MAX_Y:     regs.max_threads_y <= cfg.data;
        default: ;
      endcase
    end
  end

  wsr_front #(
    .AXIS_CAP (AXIS_CAP)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .cfg  (regs),
    .req  (req),
    .job  (push_job),
    .push (push),
    .full (full)
  );

  wsr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  wsr_back #(
    .RANK_DEPTH (RANK_DEPTH)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .job   (head),
    .empty (empty),
    .pop   (pop),
    .rsp   (rsp)
  );

endmodule

`default_nettype wire

FILE: src/wsr_div.sv
// ----------------------------------------------------------------------------
// wsr_div
// Restoring serial divider, one quotient bit per cycle, 24-bit by 11-bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsr_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [23:0] dividend,
  input  logic [10:0] divisor,
  output logic        done,
  output logic [23:0] quotient,
  output logic [10:0] remainder
);

  logic        busy;
  logic [4:0]  step;
  logic [10:0] rem;
  logic [23:0] quo;
  logic [10:0] dvs;
  logic [11:0] shifted;
  logic        fits;

  always_comb begin
    shifted = {rem, quo[23]};
    fits    = (shifted >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 5'd1;
        if (step == 5'(wsr_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[22:0], fits};
      rem <= fits ? 11'(shifted - {1'b0, dvs}) : shifted[10:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

FILE: src/wsr_queue.sv
// ----------------------------------------------------------------------------
// wsr_queue
// Short job queue between the setup front and the scoring back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  wsr_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output wsr_pkg::job_t head,
  output logic          empty
);

  localparam int PW = (wsr_pkg::QUEUE_DEPTH > 1) ? $clog2(wsr_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(wsr_pkg::QUEUE_DEPTH + 1);

  wsr_pkg::job_t   slots [wsr_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(wsr_pkg::QUEUE_DEPTH - 1)) ? '0 : PW'(p + PW'(1));
  endfunction

  assign full  = (count == CW'(wsr_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("job popped from empty queue");
`endif

endmodule

`default_nettype wire

FILE: src/wsr_front.sv
// ----------------------------------------------------------------------------
// wsr_front
// Accepts requests, derives budget, target and minimum thread count, and
// prepares per-axis round-up sizes with a shared serial divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsr_front #(
  parameter int AXIS_CAP = wsr_pkg::DEFAULT_AXIS_CAP
) (
  input  logic          clk,
  input  logic          rst,
  input  wsr_pkg::cfg_t cfg,
  wsr_req_if.sink       req,
  output wsr_pkg::job_t job,
  output logic          push,
  input  logic          full
);

  localparam logic [16:0] AXL = 17'(AXIS_CAP);

  wsr_pkg::front_state_t state, state_next;
  wsr_pkg::div_op_t      op;
  logic                  div_run;

  logic [23:0] eh, ew;
  logic [10:0] wide, wave, ax, ay, budget, minthr, wlx, wly, sw;
  logic [4:0]  lim;
  logic [24:0] rxl, rxw, ryl, ryw;
  logic [21:0] prod;
  logic [47:0] area;

  logic [10:0] wave_c, mt_c, ax_c, ay_c, budget_c, minthr_c, wlx_c, wly_c;
  logic [10:0] sg_c, simd_c, half_c, tw_c, tmin_c;
  logic [23:0] eh_c, ew_c;

  logic        div_start, div_done;
  logic [23:0] div_a, div_q;
  logic [10:0] div_b, div_r;
  logic [24:0] ru_c;

  always_comb begin
    sg_c   = (cfg.sg_width == '0) ? 11'd1 : cfg.sg_width;
    simd_c = (cfg.simd_width == '0) ? 11'd1 : cfg.simd_width;
    wave_c = (sg_c > simd_c) ? sg_c : simd_c;
    mt_c   = (cfg.total_cap == '0) ? 11'd1 : cfg.total_cap;
    ax_c   = (cfg.max_threads_x == '0) ? 11'd1 : cfg.max_threads_x;
    if (17'(ax_c) > AXL) begin
      ax_c = AXL[10:0];
    end
    ay_c   = (cfg.max_threads_y == '0) ? 11'd1 : cfg.max_threads_y;
    if (17'(ay_c) > AXL) begin
      ay_c = AXL[10:0];
    end
    budget_c = (ax_c < mt_c) ? ax_c : mt_c;
    if ((req.thread_cap != '0) && (req.thread_cap < budget_c)) begin
      budget_c = req.thread_cap;
    end
    half_c   = (wave_c >> 1) > wsr_pkg::THREAD_FLOOR ? (wave_c >> 1) : wsr_pkg::THREAD_FLOOR;
    minthr_c = (wave_c == 11'd1) ? 11'd1 : ((half_c < budget_c) ? half_c : budget_c);
    eh_c  = (req.work_height == '0) ? 24'd1 : req.work_height;
    ew_c  = (req.work_width == '0) ? 24'd1 : req.work_width;
    wlx_c = (24'(ax_c) < ew_c) ? ax_c : ew_c[10:0];
    wly_c = (24'(ay_c) < eh_c) ? ay_c : eh_c[10:0];
    tmin_c = (wide < sw) ? wide : sw;
    tw_c   = (tmin_c == '0) ? 11'd1 : tmin_c;
  end

  always_comb begin
    unique case (op)
      wsr_pkg::OP_SPLIT: begin
        div_a = 24'(budget);
        div_b = wave;
      end
      wsr_pkg::OP_RX_LIMIT: begin
        div_a = ew;
        div_b = ax;
      end
      wsr_pkg::OP_RX_WORK: begin
        div_a = ew;
        div_b = wlx;
      end
      wsr_pkg::OP_RY_LIMIT: begin
        div_a = eh;
        div_b = ay;
      end
      default: begin
        div_a = eh;
        div_b = wly;
      end
    endcase
    ru_c = (div_r == '0) ? 25'(div_a) : 25'(div_a) + 25'(div_b) - 25'(div_r);
  end

  wsr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    div_start  = 1'b0;
    push       = 1'b0;
    unique case (state)
      wsr_pkg::F_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = wsr_pkg::F_DIV;
        end
      end
      wsr_pkg::F_DIV: begin
        div_start = !div_run;
        if (div_done && (op == wsr_pkg::OP_RY_WORK)) begin
          state_next = wsr_pkg::F_TGT;
        end
      end
      wsr_pkg::F_TGT: begin
        state_next = wsr_pkg::F_PUSH;
      end
      wsr_pkg::F_PUSH: begin
        if (!full) begin
          push       = 1'b1;
          state_next = wsr_pkg::F_IDLE;
        end
      end
      default: begin
        state_next = wsr_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= wsr_pkg::F_IDLE;
      op      <= wsr_pkg::OP_SPLIT;
      div_run <= 1'b0;
    end else begin
      state <= state_next;
      if (state == wsr_pkg::F_IDLE) begin
        op      <= wsr_pkg::OP_SPLIT;
        div_run <= 1'b0;
      end else if (state == wsr_pkg::F_DIV) begin
        if (div_start) begin
          div_run <= 1'b1;
        end else if (div_done) begin
          div_run <= 1'b0;
          if (op != wsr_pkg::OP_RY_WORK) begin
            op <= wsr_pkg::div_op_t'(3'(op) + 3'd1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      eh     <= eh_c;
      ew     <= ew_c;
      wide   <= req.wide_waves;
      lim    <= req.result_limit;
      wave   <= wave_c;
      ax     <= ax_c;
      ay     <= ay_c;
      budget <= budget_c;
      minthr <= minthr_c;
      wlx    <= wlx_c;
      wly    <= wly_c;
    end
    if ((state == wsr_pkg::F_DIV) && div_done) begin
      unique case (op)
        wsr_pkg::OP_SPLIT:    sw  <= (div_q[10:0] == '0) ? 11'd1 : div_q[10:0];
        wsr_pkg::OP_RX_LIMIT: rxl <= ru_c;
        wsr_pkg::OP_RX_WORK:  rxw <= ru_c;
        wsr_pkg::OP_RY_LIMIT: ryl <= ru_c;
        default:              ryw <= ru_c;
      endcase
    end
    if (state == wsr_pkg::F_TGT) begin
      prod <= {11'b0, wave} * {11'b0, tw_c};
      area <= {24'b0, eh} * {24'b0, ew};
    end
  end

  always_comb begin
    job.eh     = eh;
    job.ew     = ew;
    job.area   = area;
    job.budget = budget;
    if (wave == 11'd1) begin
      job.target = budget;
    end else begin
      job.target = (22'(budget) < prod) ? budget : prod[10:0];
    end
    job.minthr = minthr;
    job.ax     = ax;
    job.ay     = ay;
    job.wlx    = wlx;
    job.wly    = wly;
    job.rxl    = rxl;
    job.rxw    = rxw;
    job.ryl    = ryl;
    job.ryw    = ryw;
    job.lim    = lim;
  end

endmodule

`default_nettype wire

FILE: src/wsr_back.sv
// ----------------------------------------------------------------------------
// wsr_back
// Scores every candidate pair of one job, one pair per cycle through a short
// pipeline, keeps a sorted best list and streams it out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsr_back #(
  parameter int RANK_DEPTH = wsr_pkg::DEFAULT_RANK_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  wsr_pkg::job_t job,
  input  logic          empty,
  output logic          pop,
  wsr_rsp_if.source     rsp
);

  localparam int CW = $clog2(RANK_DEPTH + 1);
  localparam int IW = (RANK_DEPTH > 1) ? $clog2(RANK_DEPTH) : 1;

  wsr_pkg::back_state_t state, state_next;
  logic [3:0]  i, j;
  logic        scan_last, load, last_out;

  logic        s1_vld;
  logic [10:0] s1_x, s1_y;
  logic [21:0] s1_tot;
  logic [34:0] s1_pa, s1_pb;
  logic [49:0] s1_pw;

  logic           s2_vld;
  wsr_pkg::cand_t s2_cand;
  wsr_pkg::cand_t cand_c;
  logic           pass_c;

  wsr_pkg::cand_t best [RANK_DEPTH];
  wsr_pkg::cand_t ins  [RANK_DEPTH];
  logic [RANK_DEPTH-1:0] gt;
  logic           blocked;
  logic [CW-1:0]  cnt, k;
  logic [4:0]     lim_eff;

  logic [10:0] xv, yv;
  logic [24:0] rx, ry;
  logic        pair_ok;

  logic        ovld, olast, onone;
  logic [10:0] ox, oy;
  wsr_pkg::cand_t sel;

  always_comb begin
    lim_eff = (7'(job.lim) > 7'(RANK_DEPTH)) ? 5'(RANK_DEPTH) : job.lim;
    xv = wsr_pkg::slot_val(i, job.ax, job.wlx);
    yv = wsr_pkg::slot_val(j, job.ay, job.wly);
    rx = wsr_pkg::slot_ru(i, job.ew, xv, job.rxl, job.rxw);
    ry = wsr_pkg::slot_ru(j, job.eh, yv, job.ryl, job.ryw);
    pair_ok = wsr_pkg::slot_ok(i, job.ax, job.wlx) && wsr_pkg::slot_ok(j, job.ay, job.wly);
    scan_last = (i == wsr_pkg::SLOT_WORK) && (j == wsr_pkg::SLOT_WORK);
  end

  always_comb begin
    pass_c = (s1_tot <= 22'(job.budget)) && (s1_tot >= 22'(job.minthr));
    cand_c.agap  = (s1_pa > s1_pb) ? (s1_pa - s1_pb) : (s1_pb - s1_pa);
    cand_c.tgap  = (job.target > s1_tot[10:0]) ? (job.target - s1_tot[10:0])
                                               : (s1_tot[10:0] - job.target);
    cand_c.waste = s1_pw - 50'(job.area);
    cand_c.ntot  = ~s1_tot[10:0];
    cand_c.nx    = ~s1_x;
    cand_c.ny    = ~s1_y;
  end

  always_comb begin
    blocked = (lim_eff == '0);
    for (int n = 0; n < RANK_DEPTH; n++) begin
      gt[n] = (n < int'(cnt)) && (best[n] < s2_cand);
      if (gt[n] && ((n + 1) == int'(lim_eff))) begin
        blocked = 1'b1;
      end
    end
    for (int n = 0; n < RANK_DEPTH; n++) begin
      if (gt[n]) begin
        ins[n] = best[n];
      end else if (n == 0) begin
        ins[n] = s2_cand;
      end else if (gt[(n == 0) ? 0 : n - 1]) begin
        ins[n] = s2_cand;
      end else begin
        ins[n] = best[(n == 0) ? 0 : n - 1];
      end
    end
  end

  always_comb begin
    sel        = best[k[IW-1:0]];
    last_out   = (cnt == '0) || ((k + CW'(1)) == cnt);
    state_next = state;
    load       = 1'b0;
    pop        = 1'b0;
    unique case (state)
      wsr_pkg::B_IDLE: begin
        if (!empty) begin
          state_next = wsr_pkg::B_SCAN;
        end
      end
      wsr_pkg::B_SCAN: begin
        if (scan_last) begin
          state_next = wsr_pkg::B_DRAIN;
        end
      end
      wsr_pkg::B_DRAIN: begin
        if (!s1_vld && !s2_vld) begin
          state_next = wsr_pkg::B_EMIT;
        end
      end
      wsr_pkg::B_EMIT: begin
        if (!ovld || rsp.ready) begin
          load = 1'b1;
          if (last_out) begin
            pop        = 1'b1;
            state_next = wsr_pkg::B_IDLE;
          end
        end
      end
      default: begin
        state_next = wsr_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= wsr_pkg::B_IDLE;
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      ovld   <= 1'b0;
      cnt    <= '0;
      k      <= '0;
      i      <= '0;
      j      <= '0;
    end else begin
      state  <= state_next;
      s1_vld <= (state == wsr_pkg::B_SCAN) && pair_ok;
      s2_vld <= s1_vld && pass_c;
      if ((state == wsr_pkg::B_IDLE) && !empty) begin
        i   <= '0;
        j   <= '0;
        cnt <= '0;
        k   <= '0;
      end else if (state == wsr_pkg::B_SCAN) begin
        if (j == wsr_pkg::SLOT_WORK) begin
          j <= '0;
          i <= i + 4'd1;
        end else begin
          j <= j + 4'd1;
        end
      end
      if (s2_vld && !blocked && (8'(cnt) < 8'(lim_eff))) begin
        cnt <= cnt + CW'(1);
      end
      if (load) begin
        ovld <= 1'b1;
        k    <= k + CW'(1);
      end else if (rsp.ready) begin
        ovld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_x   <= xv;
    s1_y   <= yv;
    s1_tot <= {11'b0, xv} * {11'b0, yv};
    s1_pa  <= {11'b0, job.ew} * {24'b0, yv};
    s1_pb  <= {11'b0, job.eh} * {24'b0, xv};
    s1_pw  <= {25'b0, rx} * {25'b0, ry};
    s2_cand <= cand_c;
    if (s2_vld && !blocked) begin
      for (int n = 0; n < RANK_DEPTH; n++) begin
        best[n] <= ins[n];
      end
    end
    if (load) begin
      olast <= last_out;
      onone <= (cnt == '0);
      ox    <= (cnt == '0) ? 11'd0 : ~sel.nx;
      oy    <= (cnt == '0) ? 11'd0 : ~sel.ny;
    end
  end

  assign rsp.valid      = ovld;
  assign rsp.shape_x    = ox;
  assign rsp.shape_y    = oy;
  assign rsp.is_last    = olast;
  assign rsp.none_found = onone;

`ifndef ASSERT_OFF
  a_cnt_in_limit: assert property (@(posedge clk) disable iff (rst)
    (state != wsr_pkg::B_IDLE) |-> (8'(cnt) <= 8'(lim_eff)))
    else $error("best list count above result limit");
  a_none_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.none_found) |-> (rsp.is_last && rsp.shape_x == '0 && rsp.shape_y == '0))
    else $error("none_found item malformed");
  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> (rsp.valid && rsp.is_last))
    else $error("job retired without final item");
`endif

endmodule

`default_nettype wire
